// ----- rtl/b64_pkg.sv -----
`default_nettype none

package b64_pkg;

  localparam logic [6:0] CHAR_CR  = 7'd13;
  localparam logic [6:0] CHAR_LF  = 7'd10;
  localparam logic [6:0] CHAR_PAD = 7'd61;
  localparam logic [6:0] CHAR_UPPER_A = 7'd65;
  localparam logic [6:0] CHAR_LOWER_OFS = 7'd71;
  localparam logic [6:0] CHAR_DIGIT_OFS = 7'd4;
  localparam logic [6:0] CHAR_PLUS  = 7'd43;
  localparam logic [6:0] CHAR_SLASH = 7'd47;

  localparam logic [4:0] GROUPS_PER_LINE = 5'd19;

  // one complete group handed from packer to serializer
  typedef struct packed {
    logic [23:0] word;
    logic [1:0]  nreal;
    logic        crlf;
  } b64_grp_t;

  function automatic logic [6:0] b64_char(input logic [5:0] v);
    logic [6:0] ch;
    if (v < 6'd26) begin
      ch = CHAR_UPPER_A + 7'(v);
    end else if (v < 6'd52) begin
      ch = CHAR_LOWER_OFS + 7'(v);
    end else if (v < 6'd62) begin
      ch = 7'(v) - CHAR_DIGIT_OFS;
    end else if (v == 6'd62) begin
      ch = CHAR_PLUS;
    end else begin
      ch = CHAR_SLASH;
    end
    return ch;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/b64_ifs.sv -----
`default_nettype none

interface b64_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       final_byte;

  modport source (output valid, output data_byte, output final_byte, input ready);
  modport sink (input valid, input data_byte, input final_byte, output ready);
endinterface

interface b64_char_if;
  logic       valid;
  logic       ready;
  logic [6:0] out_char;
  logic       run_end;

  modport source (output valid, output out_char, output run_end, input ready);
  modport sink (input valid, input out_char, input run_end, output ready);
endinterface

interface b64_cfg_if;
  logic valid;
  logic ready;
  logic line_breaks_on;

  modport source (output valid, output line_breaks_on, input ready);
  modport sink (input valid, input line_breaks_on, output ready);
endinterface

`default_nettype wire

// ----- rtl/b64_packer.sv -----
`default_nettype none

module b64_packer
  import b64_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  b64_byte_if.sink   in_i,
  b64_cfg_if.sink    cfg_i,
  output b64_grp_t   grp_o,
  output logic       grp_valid_o,
  input  wire logic  grp_take_i
);

  logic [15:0] held_q, held_d;
  logic [1:0]  count_q, count_d;
  logic [4:0]  line_q, line_d;
  logic        brk_q;
  b64_grp_t    grp_q, grp_d;
  logic        grp_vld_q, grp_vld_d;

  logic        in_fire;
  logic [1:0]  count;
  logic [1:0]  filled;
  logic [23:0] acc;
  logic [4:0]  line_inc;

  assign in_i.ready  = !grp_vld_q || grp_take_i;
  assign cfg_i.ready = 1'b1;
  assign in_fire     = in_i.valid && in_i.ready;
  assign grp_o       = grp_q;
  assign grp_valid_o = grp_vld_q;

  assign count    = (count_q == 2'd3) ? 2'd0 : count_q;
  assign filled   = count + 2'd1;
  assign acc      = {held_q, in_i.data_byte};
  assign line_inc = line_q + 5'd1;

  always_comb begin
    held_d    = held_q;
    count_d   = count_q;
    line_d    = line_q;
    grp_d     = grp_q;
    grp_vld_d = grp_vld_q && !grp_take_i;
    if (in_fire) begin
      if (in_i.final_byte) begin
        unique case (filled)
          2'd1:    grp_d.word = {in_i.data_byte, 16'd0};
          2'd2:    grp_d.word = {held_q[7:0], in_i.data_byte, 8'd0};
          default: grp_d.word = acc;
        endcase
        grp_d.nreal = filled;
        grp_d.crlf  = 1'b0;
        grp_vld_d   = 1'b1;
        held_d      = '0;
        count_d     = '0;
        line_d      = '0;
      end else if (filled != 2'd3) begin
        held_d  = acc[15:0];
        count_d = filled;
      end else begin
        grp_d.word  = acc;
        grp_d.nreal = 2'd3;
        grp_d.crlf  = 1'b0;
        grp_vld_d   = 1'b1;
        held_d      = '0;
        count_d     = '0;
        if (brk_q) begin
          if (line_inc >= GROUPS_PER_LINE) begin
            grp_d.crlf = 1'b1;
            line_d     = '0;
          end else begin
            line_d = line_inc;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q    <= '0;
      count_q   <= '0;
      line_q    <= '0;
      brk_q     <= 1'b1;
      grp_vld_q <= 1'b0;
    end else begin
      held_q    <= held_d;
      count_q   <= count_d;
      line_q    <= line_d;
      grp_vld_q <= grp_vld_d;
      if (cfg_i.valid) begin
        brk_q <= cfg_i.line_breaks_on;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    grp_q <= grp_d;
  end

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q != 2'd3)
    else $error("byte count out of range");

  a_line_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    line_q < GROUPS_PER_LINE)
    else $error("group count reached line length");

  a_grp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    grp_vld_q && !grp_take_i |=> grp_vld_q && $stable(grp_q))
    else $error("pending group lost or changed");

endmodule

`default_nettype wire

// ----- rtl/b64_serializer.sv -----
`default_nettype none

module b64_serializer
  import b64_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  b64_grp_t   grp_i,
  input  wire logic  grp_valid_i,
  output logic       grp_take_o,
  b64_char_if.source out_o
);

  localparam logic [2:0] IDX_LAST_CHAR = 3'd3;
  localparam logic [2:0] IDX_CR        = 3'd4;
  localparam logic [2:0] IDX_LF        = 3'd5;

  b64_grp_t   cur_q;
  logic [2:0] idx_q;
  logic       busy_q;
  logic       out_vld_q;
  logic [6:0] out_char_q;
  logic       out_end_q;

  logic       slot_free;
  logic       emit;
  logic       last;
  logic [2:0] last_idx;
  logic [5:0] sextet;
  logic [6:0] ch;

  assign slot_free  = !out_vld_q || out_o.ready;
  assign emit       = busy_q && slot_free;
  assign last_idx   = cur_q.crlf ? IDX_LF : IDX_LAST_CHAR;
  assign last       = (idx_q == last_idx);
  assign grp_take_o = grp_valid_i && (!busy_q || (emit && last));

  always_comb begin
    unique case (idx_q)
      3'd0:    sextet = cur_q.word[23:18];
      3'd1:    sextet = cur_q.word[17:12];
      3'd2:    sextet = cur_q.word[11:6];
      default: sextet = cur_q.word[5:0];
    endcase
    if (idx_q == IDX_CR) begin
      ch = CHAR_CR;
    end else if (idx_q == IDX_LF) begin
      ch = CHAR_LF;
    end else if (idx_q > {1'b0, cur_q.nreal}) begin
      ch = CHAR_PAD;
    end else begin
      ch = b64_char(sextet);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q    <= 1'b0;
      idx_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      if (grp_take_o) begin
        busy_q <= 1'b1;
        idx_q  <= '0;
      end else if (emit && last) begin
        busy_q <= 1'b0;
        idx_q  <= '0;
      end else if (emit) begin
        idx_q <= idx_q + 3'd1;
      end
      if (emit) begin
        out_vld_q <= 1'b1;
      end else if (out_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (grp_take_o) begin
      cur_q <= grp_i;
    end
    if (emit) begin
      out_char_q <= ch;
      out_end_q  <= last;
    end
  end

  assign out_o.valid    = out_vld_q;
  assign out_o.out_char = out_char_q;
  assign out_o.run_end  = out_end_q;

  a_idx_plain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q && !cur_q.crlf |-> idx_q <= IDX_LAST_CHAR)
    else $error("character index past group without line break");

  a_idx_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_q |-> idx_q == 3'd0)
    else $error("character index not cleared while idle");

  a_nreal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> cur_q.nreal != 2'd0)
    else $error("group without real bytes");

endmodule

`default_nettype wire

// ----- rtl/base64_stream_encoder_core.sv -----
`default_nettype none

// base64 stream encoder: one byte word per input handshake, one ascii character word per
// output handshake. a byte is taken whenever the group register is free;
// each third byte, or a byte marked final, forms a group that the serializer sends as four
// characters (six when a cr lf follows), one per cycle through the output register while
// the output is ready. the serializer takes the next group only as it sends the last
// character of the current one, and bytes wait while a group is pending; a final group of
// one byte still sends four characters. the first character passes the group register,
// the serializer's group register and the output register. line_breaks_on resets to 1.
module base64_stream_encoder_core
  import b64_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  b64_byte_if.sink   in_i,
  b64_cfg_if.sink    cfg_i,
  b64_char_if.source out_o
);

  b64_grp_t grp;
  logic     grp_valid;
  logic     grp_take;

  b64_packer u_packer (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .cfg_i       (cfg_i),
    .grp_o       (grp),
    .grp_valid_o (grp_valid),
    .grp_take_i  (grp_take)
  );

  b64_serializer u_serializer (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .grp_i       (grp),
    .grp_valid_i (grp_valid),
    .grp_take_o  (grp_take),
    .out_o       (out_o)
  );

endmodule

`default_nettype wire
